// ----- hw/rtl/spcrc_pkg.sv -----
// Shared types, codes and the CRC-16 step function for the servo packet receiver.
// No dependencies; every module of the block imports this package.
package spcrc_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]  HDR_FF      = 8'hFF;
    localparam logic [7:0]  HDR_FD      = 8'hFD;
    localparam logic [15:0] CRC_POLY    = 16'h8005;
    localparam logic [7:0]  MAX_RESET   = 8'hFF;
    localparam logic [8:0]  HDR_BYTES   = 9'd5;
    localparam logic [8:0]  PAYLOAD_OFS = 9'd9;
    localparam logic [15:0] SHORT_LEN   = 16'd3;

    localparam logic [1:0] EV_PAYLOAD  = 2'd0;
    localparam logic [1:0] EV_GOOD     = 2'd1;
    localparam logic [1:0] EV_CRC_ERR  = 2'd2;
    localparam logic [1:0] EV_OVERFLOW = 2'd3;

    typedef enum logic [10:0] {
        PH_HUNT0   = 11'b000_0000_0001,
        PH_HUNT1   = 11'b000_0000_0010,
        PH_HUNT2   = 11'b000_0000_0100,
        PH_RESV    = 11'b000_0000_1000,
        PH_ID      = 11'b000_0001_0000,
        PH_LEN_LO  = 11'b000_0010_0000,
        PH_LEN_HI  = 11'b000_0100_0000,
        PH_INSTR   = 11'b000_1000_0000,
        PH_PAYLOAD = 11'b001_0000_0000,
        PH_CRC_LO  = 11'b010_0000_0000,
        PH_CRC_HI  = 11'b100_0000_0000
    } t_phase;

    // One classified byte as it sits in the queue between front and back.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       is_ff;
        logic       is_fd;
    } t_qitem;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic   valid;
        t_qitem item;
    } t_qhead;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  packet_id;
        logic [7:0]  instruction;
        logic [15:0] packet_length;
        logic        last;
    } t_result;

    function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/spcrc_if.sv -----
// Stream interfaces for received bytes and for receiver events.
// Depends on nothing; valid/ready handshake, a beat moves when both are high.
interface spcrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface spcrc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  packet_id;
    logic [7:0]  instruction;
    logic [15:0] packet_length;
    logic        last;

    modport source (output valid, output event_res, output payload_byte,
                    output payload_index, output packet_id, output instruction,
                    output packet_length, output last, input ready);
    modport sink   (input valid, input event_res, input payload_byte,
                    input payload_index, input packet_id, input instruction,
                    input packet_length, input last, output ready);
endinterface

// ----- hw/rtl/servo_packet_receiver_crc_check_unit.sv -----
// Servo packet receiver with CRC-16 check.
// A byte beat is written into the queue when accepted; the decoder pops it from the
// queue head, and any event it yields is registered and driven onto o_evt.
// Throughput: one byte per cycle while o_evt is not stalled; a four-entry queue between
// the front end and the decoder absorbs output stalls, and the event register holds one result.
// Reset (i_rst_n low, synchronous): queue empty, decoder hunting, limit 255.
module servo_packet_receiver_crc_check_unit import spcrc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spcrc_in_if.sink     i_rx,
    spcrc_out_if.source  o_evt,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [7:0] r_max_bytes;
    t_qhead     w_head;
    logic       w_pop;
    logic       w_reg_hit;

    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[2] == 1'b0);
    assign prdata    = w_reg_hit ? {24'd0, r_max_bytes} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_max_bytes <= pwdata[7:0];
        end
    end

    spcrc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    spcrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_bytes (r_max_bytes),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_evt       (o_evt)
    );

endmodule

// ----- hw/rtl/spcrc_front.sv -----
// Front end: accepts byte beats, tags header bytes and queues them for the back end.
// Depends on spcrc_pkg and spcrc_in_if.
module spcrc_front import spcrc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spcrc_in_if.sink     i_rx,
    input  logic         i_pop,
    output t_qhead       o_head
);

    t_qitem                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wptr, n_wptr;
    logic [QUEUE_AW-1:0]   r_rptr, n_rptr;
    logic [QUEUE_AW:0]     r_fill, n_fill;
    logic                  w_push;
    logic                  w_pop;
    t_qitem                w_item;

    assign i_rx.ready = (r_fill != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign w_push     = i_rx.valid && i_rx.ready;
    assign w_pop      = i_pop && (r_fill != '0);

    always_comb begin
        w_item.rx_byte = i_rx.rx_byte;
        w_item.is_ff   = (i_rx.rx_byte == HDR_FF);
        w_item.is_fd   = (i_rx.rx_byte == HDR_FD);
    end

    always_comb begin
        n_wptr = w_push ? r_wptr + QUEUE_AW'(1) : r_wptr;
        n_rptr = w_pop  ? r_rptr + QUEUE_AW'(1) : r_rptr;
        n_fill = r_fill + (QUEUE_AW+1)'(w_push) - (QUEUE_AW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_item;
        end
    end

    assign o_head.valid = (r_fill != '0);
    assign o_head.item  = r_mem[r_rptr];

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue fill count above depth");

    a_fill_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_fill == $past(r_fill) + (QUEUE_AW+1)'(1)))
        else $error("queue fill count lost a pushed beat");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == (QUEUE_AW+1)'(QUEUE_DEPTH)) |-> !w_push)
        else $error("byte beat accepted into a full queue");

endmodule

// ----- hw/rtl/spcrc_back.sv -----
// Back end: packet decoder, running CRC-16 and the registered event output.
// Depends on spcrc_pkg and spcrc_out_if; takes classified bytes from spcrc_front.
module spcrc_back import spcrc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [7:0]   i_max_bytes,
    input  t_qhead       i_head,
    output logic         o_pop,
    spcrc_out_if.source  o_evt
);

    t_phase       r_phase, n_phase;
    logic [7:0]   r_count, n_count;
    logic [15:0]  r_len, n_len;
    logic [15:0]  r_crc, n_crc;
    logic [7:0]   r_id, n_id;
    logic [7:0]   r_instr, n_instr;
    logic [7:0]   r_crc_lo, n_crc_lo;
    logic         r_out_valid, n_out_valid;
    t_result      r_out, n_out;

    logic [8:0]   w_cnt;
    logic [15:0]  w_crc_step;
    logic [15:0]  w_got;
    logic [7:0]   w_b;

    assign o_pop      = i_head.valid && (!r_out_valid || o_evt.ready);
    assign w_b        = i_head.item.rx_byte;
    assign w_cnt      = {1'b0, r_count} + 9'd1;
    assign w_crc_step = crc16_add(r_crc, w_b);
    assign w_got      = {w_b, r_crc_lo};

    always_comb begin
        logic emit;
        logic resync;
        emit        = 1'b0;
        resync      = 1'b0;
        n_phase     = r_phase;
        n_count     = r_count;
        n_len       = r_len;
        n_crc       = r_crc;
        n_id        = r_id;
        n_instr     = r_instr;
        n_crc_lo    = r_crc_lo;
        n_out       = r_out;
        n_out.packet_id     = r_id;
        n_out.instruction   = r_instr;
        n_out.packet_length = r_len;
        n_out.payload_byte  = 8'd0;
        n_out.payload_index = 8'd0;
        n_out.last          = 1'b1;
        n_out.event_res     = EV_OVERFLOW;

        // An FF after FF FF is a stretched header and leaves everything alone.
        if (o_pop && !(r_phase == PH_HUNT2 && i_head.item.is_ff)) begin
            if (w_cnt >= {1'b0, i_max_bytes}) begin
                emit   = 1'b1;
                resync = 1'b1;
            end else begin
                n_count = w_cnt[7:0];
                case (r_phase)
                    PH_HUNT0, PH_HUNT1: begin
                        if (i_head.item.is_ff) begin
                            n_crc   = w_crc_step;
                            n_phase = (r_phase == PH_HUNT0) ? PH_HUNT1 : PH_HUNT2;
                        end else begin
                            resync = 1'b1;
                        end
                    end
                    PH_HUNT2: begin
                        if (i_head.item.is_fd) begin
                            n_crc   = w_crc_step;
                            n_phase = PH_RESV;
                        end else begin
                            resync = 1'b1;
                        end
                    end
                    PH_RESV: begin
                        n_crc   = w_crc_step;
                        n_phase = PH_ID;
                    end
                    PH_ID: begin
                        n_crc   = w_crc_step;
                        n_id    = w_b;
                        n_phase = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_crc   = w_crc_step;
                        n_len   = {8'd0, w_b};
                        n_phase = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        n_crc   = w_crc_step;
                        n_len   = {w_b, r_len[7:0]};
                        n_phase = PH_INSTR;
                    end
                    PH_INSTR: begin
                        n_crc   = w_crc_step;
                        n_instr = w_b;
                        n_phase = (r_len <= SHORT_LEN) ? PH_CRC_LO : PH_PAYLOAD;
                    end
                    PH_PAYLOAD: begin
                        n_crc               = w_crc_step;
                        emit                = 1'b1;
                        n_out.event_res     = EV_PAYLOAD;
                        n_out.payload_byte  = w_b;
                        n_out.payload_index = (w_cnt >= PAYLOAD_OFS)
                                              ? 8'(w_cnt - PAYLOAD_OFS) : 8'd0;
                        n_out.last          = 1'b0;
                        if ({8'd0, w_cnt} >= {1'b0, r_len} + 17'({8'd0, HDR_BYTES})) begin
                            n_phase = PH_CRC_LO;
                        end
                    end
                    PH_CRC_LO: begin
                        n_crc_lo = w_b;
                        n_phase  = PH_CRC_HI;
                    end
                    PH_CRC_HI: begin
                        emit            = 1'b1;
                        resync          = 1'b1;
                        n_out.event_res = (w_got == r_crc) ? EV_GOOD : EV_CRC_ERR;
                    end
                    default: begin
                        resync = 1'b1;
                    end
                endcase
            end
        end

        if (resync) begin
            n_phase  = PH_HUNT0;
            n_count  = 8'd0;
            n_crc    = 16'd0;
            n_len    = 16'd0;
            n_id     = 8'd0;
            n_instr  = 8'd0;
            n_crc_lo = 8'd0;
        end

        if (emit) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && !o_evt.ready;
            n_out       = r_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT0;
            r_count     <= 8'd0;
            r_len       <= 16'd0;
            r_crc       <= 16'd0;
            r_id        <= 8'd0;
            r_instr     <= 8'd0;
            r_crc_lo    <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_len       <= n_len;
            r_crc       <= n_crc;
            r_id        <= n_id;
            r_instr     <= n_instr;
            r_crc_lo    <= n_crc_lo;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_evt.valid         = r_out_valid;
    assign o_evt.event_res     = r_out.event_res;
    assign o_evt.payload_byte  = r_out.payload_byte;
    assign o_evt.payload_index = r_out.payload_index;
    assign o_evt.packet_id     = r_out.packet_id;
    assign o_evt.instruction   = r_out.instruction;
    assign o_evt.packet_length = r_out.packet_length;
    assign o_evt.last          = r_out.last;

    a_last_matches_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.last == (r_out.event_res != EV_PAYLOAD)))
        else $error("end flag disagrees with event code");

    a_payload_needs_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_len > SHORT_LEN))
        else $error("payload phase entered with a short length field");

    a_event_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_evt.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("event beat changed while stalled");

endmodule
